>>> design/sip_pkg.sv
// ----------------------------------------------------------------------------
// sip_pkg
// Shared constants and types for the segment intersection pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package sip_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int OUT_BITS       = 32;

  // control that travels alongside each item in the pipeline
  typedef struct packed {
    logic vld;
    logic hit;
  } sip_tag_t;

endpackage

`default_nettype wire

>>> design/sip_div.sv
// ----------------------------------------------------------------------------
// sip_div
// Twin restoring dividers, one quotient bit per stage, sharing the divisor.
// ----------------------------------------------------------------------------
`default_nettype none

module sip_div
  import sip_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  wire  logic                      clk,
  input  wire  logic                      rst_n,
  input  wire  logic                      en,
  input  wire  sip_tag_t                  tag_in,
  input  wire  logic [3*COORD_BITS+4:0]   numx_mag,
  input  wire  logic                      negx,
  input  wire  logic [3*COORD_BITS+4:0]   numy_mag,
  input  wire  logic                      negy,
  input  wire  logic [2*COORD_BITS+2:0]   den_mag,
  output sip_tag_t                        tag_out,
  output logic [OUT_BITS-1:0]             cross_x,
  output logic [OUT_BITS-1:0]             cross_y
);

  localparam int NW   = 3*COORD_BITS + 5;
  localparam int DENW = 2*COORD_BITS + 3;
  localparam int RW   = DENW + 1;
  localparam int Q    = COORD_BITS + FRAC_BITS;
  localparam int DVW  = NW + FRAC_BITS;

  logic [DVW-1:0] dvx, dvy;
  assign dvx = {numx_mag, {FRAC_BITS{1'b0}}};
  assign dvy = {numy_mag, {FRAC_BITS{1'b0}}};

  sip_tag_t         tag_r [0:Q];
  logic [RW-1:0]    rx_r  [0:Q];
  logic [RW-1:0]    ry_r  [0:Q];
  logic [Q-1:0]     lx_r  [0:Q];
  logic [Q-1:0]     ly_r  [0:Q];
  logic [Q-1:0]     qx_r  [0:Q];
  logic [Q-1:0]     qy_r  [0:Q];
  logic [DENW-1:0]  dm_r  [0:Q];
  logic             nx_r  [0:Q];
  logic             ny_r  [0:Q];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r[0] <= '0;
    end else if (en) begin
      tag_r[0] <= tag_in;
    end
  end

  // quotient is below 2^Q, so the bits above Q form a remainder below the divisor
  always_ff @(posedge clk) begin
    if (en) begin
      rx_r[0] <= dvx[Q +: RW];
      ry_r[0] <= dvy[Q +: RW];
      lx_r[0] <= dvx[Q-1:0];
      ly_r[0] <= dvy[Q-1:0];
      qx_r[0] <= '0;
      qy_r[0] <= '0;
      dm_r[0] <= den_mag;
      nx_r[0] <= negx;
      ny_r[0] <= negy;
    end
  end

  for (genvar k = 0; k < Q; k++) begin : g_stage
    logic [RW:0] tx, ty;
    assign tx = {rx_r[k], lx_r[k][Q-1-k]} - {2'b00, dm_r[k]};
    assign ty = {ry_r[k], ly_r[k][Q-1-k]} - {2'b00, dm_r[k]};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        tag_r[k+1] <= '0;
      end else if (en) begin
        tag_r[k+1] <= tag_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rx_r[k+1] <= tx[RW] ? {rx_r[k][RW-2:0], lx_r[k][Q-1-k]} : tx[RW-1:0];
        ry_r[k+1] <= ty[RW] ? {ry_r[k][RW-2:0], ly_r[k][Q-1-k]} : ty[RW-1:0];
        qx_r[k+1] <= {qx_r[k][Q-2:0], ~tx[RW]};
        qy_r[k+1] <= {qy_r[k][Q-2:0], ~ty[RW]};
        lx_r[k+1] <= lx_r[k];
        ly_r[k+1] <= ly_r[k];
        dm_r[k+1] <= dm_r[k];
        nx_r[k+1] <= nx_r[k];
        ny_r[k+1] <= ny_r[k];
      end
    end
  end

  logic [Q:0] sx, sy;
  assign sx = nx_r[Q] ? (Q+1)'(-{1'b0, qx_r[Q]}) : {1'b0, qx_r[Q]};
  assign sy = ny_r[Q] ? (Q+1)'(-{1'b0, qy_r[Q]}) : {1'b0, qy_r[Q]};

  logic [OUT_BITS-1:0] fx, fy;
  if (Q + 1 >= OUT_BITS) begin : g_trunc
    assign fx = sx[OUT_BITS-1:0];
    assign fy = sy[OUT_BITS-1:0];
  end else begin : g_sext
    assign fx = {{(OUT_BITS-Q-1){sx[Q]}}, sx};
    assign fy = {{(OUT_BITS-Q-1){sy[Q]}}, sy};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_out <= '0;
    end else if (en) begin
      tag_out <= tag_r[Q];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cross_x <= tag_r[Q].hit ? fx : '0;
      cross_y <= tag_r[Q].hit ? fy : '0;
    end
  end

endmodule

`default_nettype wire

>>> design/segment_intersection_point.sv
// Throughput: one item per cycle; the whole pipeline advances whenever the
// output register is empty or being taken, so a stall freezes every stage.
// Depth is set by the bit-per-stage divider, one stage per quotient bit.
// Reset clears all valid bits; payload registers are not reset.
// ----------------------------------------------------------------------------
// segment_intersection_point
// Pipelined 2D segment crossing test with fixed-point crossing coordinates.
// ----------------------------------------------------------------------------
`default_nettype none

module segment_intersection_point
  import sip_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  wire  logic                      clk,
  input  wire  logic                      rst_n,
  input  wire  logic                      in_tvalid,
  output logic                            in_tready,
  // a_start_x, a_start_y, a_end_x, a_end_y, b_start_x, b_start_y, b_end_x, b_end_y
  input  wire  logic [8*COORD_BITS-1:0]   in_tdata,
  output logic                            out_tvalid,
  input  wire  logic                      out_tready,
  // cross_x, cross_y
  output logic [2*OUT_BITS-1:0]           out_tdata,
  // hit
  output logic                            out_tuser
);

  localparam int C    = COORD_BITS;
  localparam int DW   = C + 1;
  localparam int PW   = 2*C + 2;
  localparam int DENW = 2*C + 3;
  localparam int NW   = 3*C + 5;

  logic en;
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  function automatic logic signed [DW-1:0] fld(input logic [8*COORD_BITS-1:0] d, input int i);
    logic [C-1:0] v;
    v = d[i*C +: C];
    return {v[C-1], v};
  endfunction

  function automatic logic in_unit(input logic signed [DENW-1:0] n,
                                   input logic signed [DENW-1:0] d);
    if (d > 0) return (n >= 0) && (n <= d);
    return (n <= 0) && (n >= d);
  endfunction

  // stage 1: differences
  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;
  logic signed [DW-1:0] d1x_r, d1y_r, d2x_r, d2y_r, ex_r, ey_r, ax_r, ay_r;

  always_ff @(posedge clk) begin
    if (en) begin
      d1x_r <= fld(in_tdata, 2) - fld(in_tdata, 0);
      d1y_r <= fld(in_tdata, 3) - fld(in_tdata, 1);
      d2x_r <= fld(in_tdata, 6) - fld(in_tdata, 4);
      d2y_r <= fld(in_tdata, 7) - fld(in_tdata, 5);
      ex_r  <= fld(in_tdata, 0) - fld(in_tdata, 4);
      ey_r  <= fld(in_tdata, 1) - fld(in_tdata, 5);
      ax_r  <= fld(in_tdata, 0);
      ay_r  <= fld(in_tdata, 1);
    end
  end

  // stage 2: cross products
  logic signed [PW-1:0] pa_r, pb_r, pc_r, pd_r, pe_r, pf_r;
  logic signed [DW-1:0] d1x2_r, d1y2_r, ax2_r, ay2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      pa_r   <= PW'(d1x_r) * PW'(d2y_r);
      pb_r   <= PW'(d1y_r) * PW'(d2x_r);
      pc_r   <= PW'(ey_r)  * PW'(d2x_r);
      pd_r   <= PW'(ex_r)  * PW'(d2y_r);
      pe_r   <= PW'(ey_r)  * PW'(d1x_r);
      pf_r   <= PW'(ex_r)  * PW'(d1y_r);
      d1x2_r <= d1x_r;
      d1y2_r <= d1y_r;
      ax2_r  <= ax_r;
      ay2_r  <= ay_r;
    end
  end

  // stage 3: determinant and parameter numerators
  logic signed [DENW-1:0] den_r, nr_r, ns_r;
  logic signed [DW-1:0]   d1x3_r, d1y3_r, ax3_r, ay3_r;

  always_ff @(posedge clk) begin
    if (en) begin
      den_r  <= DENW'(pa_r) - DENW'(pb_r);
      nr_r   <= DENW'(pc_r) - DENW'(pd_r);
      ns_r   <= DENW'(pe_r) - DENW'(pf_r);
      d1x3_r <= d1x2_r;
      d1y3_r <= d1y2_r;
      ax3_r  <= ax2_r;
      ay3_r  <= ay2_r;
    end
  end

  // stage 4: range test and numerator products
  logic                   hit4_r;
  logic signed [NW-1:0]   axd_r, ayd_r, nrx_r, nry_r;
  logic signed [DENW-1:0] den4_r;

  always_ff @(posedge clk) begin
    if (en) begin
      hit4_r <= (den_r != 0) && in_unit(nr_r, den_r) && in_unit(ns_r, den_r);
      axd_r  <= NW'(ax3_r) * NW'(den_r);
      ayd_r  <= NW'(ay3_r) * NW'(den_r);
      nrx_r  <= NW'(nr_r) * NW'(d1x3_r);
      nry_r  <= NW'(nr_r) * NW'(d1y3_r);
      den4_r <= den_r;
    end
  end

  // stage 5: point numerators
  logic                   hit5_r;
  logic signed [NW-1:0]   numx_r, numy_r;
  logic signed [DENW-1:0] den5_r;

  always_ff @(posedge clk) begin
    if (en) begin
      hit5_r <= hit4_r;
      numx_r <= axd_r + nrx_r;
      numy_r <= ayd_r + nry_r;
      den5_r <= den4_r;
    end
  end

  // stage 6: magnitudes and quotient signs
  logic              hit6_r, negx_r, negy_r;
  logic [NW-1:0]     magx_r, magy_r;
  logic [DENW-1:0]   magd_r;

  always_ff @(posedge clk) begin
    if (en) begin
      hit6_r <= hit5_r;
      negx_r <= numx_r[NW-1] ^ den5_r[DENW-1];
      negy_r <= numy_r[NW-1] ^ den5_r[DENW-1];
      magx_r <= numx_r[NW-1] ? NW'(-numx_r) : NW'(numx_r);
      magy_r <= numy_r[NW-1] ? NW'(-numy_r) : NW'(numy_r);
      magd_r <= den5_r[DENW-1] ? DENW'(-den5_r) : DENW'(den5_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_tvalid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
    end
  end

  sip_tag_t tag6, tag_o;
  assign tag6.vld = v6_r;
  assign tag6.hit = hit6_r;

  logic [OUT_BITS-1:0] cx, cy;

  sip_div #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .tag_in   (tag6),
    .numx_mag (magx_r),
    .negx     (negx_r),
    .numy_mag (magy_r),
    .negy     (negy_r),
    .den_mag  (magd_r),
    .tag_out  (tag_o),
    .cross_x  (cx),
    .cross_y  (cy)
  );

  assign out_tvalid = tag_o.vld;
  assign out_tuser  = tag_o.hit;
  assign out_tdata  = {cy, cx};

  // a miss always carries a zero point
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == '0)
    else $error("miss result with nonzero point");

  // zero determinant never reaches the divider as a hit
  a_den_zero: assert property (@(posedge clk) disable iff (!rst_n)
    en && v3_r && den_r == 0 |=> !hit4_r)
    else $error("hit flagged with zero determinant");

  // a held result stays stable until it is taken
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

endmodule

`default_nettype wire

>>> dv/segment_intersection_point_tb.sv
// ----------------------------------------------------------------------------
// segment_intersection_point_tb
// Drives segment pairs into the crossing pipeline, predicts the hit flag and
// the Q16.16 crossing point for each item, and checks every result in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module segment_intersection_point_tb;
  import sip_pkg::*;

  localparam int CB       = COORD_BITS_DEF;
  localparam int FB       = FRAC_BITS_DEF;
  localparam int LATENCY  = CB + FB + 8;
  localparam int WDOG_MAX = 20000;

  typedef struct packed {
    logic signed [CB-1:0] bey, bex, bsy, bsx, aey, aex, asy, asx;
  } seg_pair_t;

  typedef struct {
    bit                          hit;
    logic signed [OUT_BITS-1:0]  x;
    logic signed [OUT_BITS-1:0]  y;
  } crossing_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [8*CB-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [2*OUT_BITS-1:0] out_tdata;
  logic out_tuser;

  segment_intersection_point u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  seg_pair_t pending_pairs[$];
  crossing_t expected_points[$];
  int  mismatches = 0;
  int  wdog = 0;
  bit  calm = 0;          // no random idling while set
  bit  hold_out = 0;      // long receiver hold-off
  bit  pause_in = 0;      // sender waits for the pipe to drain
  bit  stim_done = 0;
  bit  in_acc = 0;        // input item taken at the last rising edge

  function automatic logic signed [63:0] mag(logic signed [63:0] v);
    return v < 0 ? -v : v;
  endfunction

  // num/den scaled by 2^FB, truncated toward zero, wrapped to 32 bits
  function automatic logic [OUT_BITS-1:0] q_div(logic signed [63:0] num,
                                                logic signed [63:0] den);
    logic [63:0] n, d, q, r, res;
    n = mag(num);
    d = mag(den);
    q = n / d;
    r = n % d;
    res = (q << FB) + ((r << FB) / d);
    if ((num < 0) != (den < 0)) res = -res;
    return res[OUT_BITS-1:0];
  endfunction

  function automatic bit unit_range(logic signed [63:0] num, logic signed [63:0] den);
    if (den > 0) return num >= 0 && num <= den;
    return num <= 0 && num >= den;
  endfunction

  function automatic crossing_t predict_crossing(seg_pair_t p);
    logic signed [63:0] d1x, d1y, d2x, d2y, ex, ey, den, nr, ns;
    crossing_t c;
    d1x = 64'(p.aex) - 64'(p.asx);
    d1y = 64'(p.aey) - 64'(p.asy);
    d2x = 64'(p.bex) - 64'(p.bsx);
    d2y = 64'(p.bey) - 64'(p.bsy);
    ex  = 64'(p.asx) - 64'(p.bsx);
    ey  = 64'(p.asy) - 64'(p.bsy);
    den = d1x * d2y - d1y * d2x;
    nr  = ey * d2x - ex * d2y;
    ns  = ey * d1x - ex * d1y;
    c.hit = 0;
    c.x = '0;
    c.y = '0;
    if (den != 0 && unit_range(nr, den) && unit_range(ns, den)) begin
      c.hit = 1;
      c.x = q_div(64'(p.asx) * den + nr * d1x, den);
      c.y = q_div(64'(p.asy) * den + nr * d1y, den);
    end
    return c;
  endfunction

  function automatic logic [CB-1:0] rnd_coord(int mode);
    case (mode)
      0: return CB'($urandom);
      1: return CB'($signed($urandom_range(0, 64)) - 32);
      default: return CB'($signed($urandom_range(0, 2000)) - 1000);
    endcase
  endfunction

  function automatic seg_pair_t rnd_pair();
    seg_pair_t p;
    int m;
    m = $urandom_range(0, 2);
    p = {rnd_coord(m), rnd_coord(m), rnd_coord(m), rnd_coord(m),
         rnd_coord(m), rnd_coord(m), rnd_coord(m), rnd_coord(m)};
    // crossing-biased: b runs across the span of a
    if ($urandom_range(0, 99) < 50) begin
      p.bsx = p.asx + CB'($signed($urandom_range(0, 40)) - 20);
      p.bsy = p.aey + CB'($signed($urandom_range(0, 40)) - 20);
      p.bex = p.aex + CB'($signed($urandom_range(0, 40)) - 20);
      p.bey = p.asy + CB'($signed($urandom_range(0, 40)) - 20);
    end
    return p;
  endfunction

  function automatic seg_pair_t mk(int ax0, int ay0, int ax1, int ay1,
                                   int bx0, int by0, int bx1, int by1);
    seg_pair_t p;
    p = {CB'(by1), CB'(bx1), CB'(by0), CB'(bx0), CB'(ay1), CB'(ax1), CB'(ay0), CB'(ax0)};
    return p;
  endfunction

  // driver
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_tvalid || in_acc) begin
        if (pending_pairs.size() > 0 && !pause_in &&
            (calm || $urandom_range(0, 99) >= 16)) begin
          in_tdata  <= pending_pairs.pop_front();
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
      out_tready <= !hold_out && (calm || $urandom_range(0, 99) >= 16);
    end
  end

  // monitor and scoreboard
  always @(posedge clk) begin
    crossing_t e;
    bit took;
    took = 0;
    if (rst_n) begin
      in_acc <= in_tvalid && in_tready;
      if (in_tvalid && in_tready) begin
        expected_points.push_back(predict_crossing(seg_pair_t'(in_tdata)));
        took = 1;
      end
      if (out_tvalid && out_tready) begin
        took = 1;
        if (expected_points.size() == 0) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10) $display("unexpected item: hit=%0d data=%h",
                                        out_tuser, out_tdata);
        end else begin
          e = expected_points.pop_front();
          if (out_tuser !== e.hit || out_tdata[OUT_BITS-1:0] !== e.x ||
              out_tdata[2*OUT_BITS-1:OUT_BITS] !== e.y) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10)
              $display("mismatch: exp hit=%0d x=%h y=%h, got hit=%0d x=%h y=%h",
                       e.hit, e.x, e.y, out_tuser, out_tdata[OUT_BITS-1:0],
                       out_tdata[2*OUT_BITS-1:OUT_BITS]);
          end
        end
      end
      wdog <= took ? 0 : wdog + 1;
      if (wdog >= WDOG_MAX) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    int i;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: crossings, endpoint touches, parallel, collinear, extremes
    pending_pairs.push_back(mk(0, 0, 10, 10, 0, 10, 10, 0));
    pending_pairs.push_back(mk(0, 0, 3, 0, 1, -1, 2, 2));
    pending_pairs.push_back(mk(0, 0, 10, 0, 10, 0, 10, 5));
    pending_pairs.push_back(mk(0, 0, 10, 0, 0, 0, -5, 5));
    pending_pairs.push_back(mk(0, 0, 10, 0, 0, 1, 10, 1));
    pending_pairs.push_back(mk(0, 0, 10, 0, 5, 0, 15, 0));
    pending_pairs.push_back(mk(0, 0, 10, 0, 11, -1, 11, 1));
    pending_pairs.push_back(mk(0, 0, 1, 0, 0, 0, 1, 0));
    pending_pairs.push_back(mk(3, 3, 3, 3, 0, 0, 5, 5));
    pending_pairs.push_back(mk(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768));
    pending_pairs.push_back(mk(32767, -32768, -32768, 32767, -32768, -32768, 32767, 32767));
    pending_pairs.push_back(mk(-32768, 0, 32767, 0, 0, -32768, 0, 32767));
    pending_pairs.push_back(mk(-32768, -32768, -32768, 32767, -32768, 0, 32767, 1));
    pending_pairs.push_back(mk(0, 0, 3, 7, 1, 5, 2, -1));
    pending_pairs.push_back(mk(-7, 2, 5, -3, -1, -9, 4, 8));
    pending_pairs.push_back(mk(-1, -1, -1, -1, -1, -1, -1, -1));
    pending_pairs.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0));
    pending_pairs.push_back(mk(32767, 32767, -32768, -32768, 32767, -32768, -32768, 32767));
    calm = 1;
    wait (pending_pairs.size() == 0);
    calm = 0;

    // receiver holds off while the sender keeps offering items
    hold_out = 1;
    for (i = 0; i < 120; i++) pending_pairs.push_back(rnd_pair());
    for (i = 0; i < 200; i++) @(posedge clk);
    hold_out = 0;
    wait (pending_pairs.size() == 0);

    // sender pauses until the pipe has drained
    pause_in = 1;
    wait (expected_points.size() == 0);
    pause_in = 0;

    for (i = 0; i < 380; i++) pending_pairs.push_back(rnd_pair());
    wait (pending_pairs.size() == 0);
    calm = 1;
    for (i = 0; i < 200; i++) pending_pairs.push_back(rnd_pair());
    wait (pending_pairs.size() == 0);
    calm = 0;
    for (i = 0; i < 200; i++) pending_pairs.push_back(rnd_pair());
    wait (pending_pairs.size() == 0);
    @(posedge clk);
    wait (!in_tvalid);
    stim_done = 1;

    wait (expected_points.size() == 0);
    for (i = 0; i < 2 * LATENCY; i++) @(posedge clk);
    if (mismatches == 0 && expected_points.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/sip_pkg.sv
design/sip_div.sv
design/segment_intersection_point.sv
dv/segment_intersection_point_tb.sv
